FILE: rtl/core/signed_int_to_ascii_radix_unit_assert.svh
// Assertion macros used by the checker file of the radix text unit.
`ifndef SIGNED_INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_ASCII_RADIX_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define SITAR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define SITAR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sitar_pkg.sv
// Shared types, constants and helpers of the radix text unit.
`timescale 1ns / 1ps

package sitar_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	localparam radix_t RADIX_RESET = RADIX_DEC;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] HEX_GAP  = 8'd7;
	localparam logic [3:0] DEC_MAX  = 4'd9;

	typedef struct packed {
		logic load;
		logic dec;
		logic step;
	} conv_cmd_t;

	function automatic logic [7:0] digit_char(logic [3:0] d);
		logic [7:0] c;
		c = CH_ZERO + {4'd0, d};
		if (d > DEC_MAX) c = c + HEX_GAP;
		return c;
	endfunction

endpackage

FILE: rtl/core/signed_int_to_ascii_radix_unit.sv
// Top level of the signed integer to ASCII text unit.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, value        | in
//  output  | out_valid, out_stall, character, | out
//          | last                             |
//  config  | cfg_we, cfg_wdata                | in
//
// One number at a time; in_stall is high from the accepting edge until the last
// character has been loaded into the output register.
// Per number: a load, then shift/add-3 steps on the digit buffer for decimal only,
// a skip over leading zero digits, a minus sign if negative and one character per digit.
// Output stall holds the output register and pauses the sequencer in its sign and emit states.
// Reset clears the sequencer and sets the radix to decimal.
`timescale 1ns / 1ps

module signed_int_to_ascii_radix_unit import sitar_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    character,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata
);

	localparam int IW = $clog2(VALUE_WIDTH);

	radix_t                 radix_q;
	conv_cmd_t              cmd;
	logic [VALUE_WIDTH-1:0] mag;
	logic [IW-1:0]          idx;
	logic [3:0]             digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= radix_t'(cfg_wdata);
		end
	end

	sitar_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last),
		.radix     (radix_q),
		.cmd       (cmd),
		.mag       (mag),
		.idx       (idx),
		.digit     (digit)
	);

	sitar_conv #(.VALUE_WIDTH(VALUE_WIDTH)) u_conv (
		.clk   (clk),
		.cmd   (cmd),
		.mag   (mag),
		.radix (radix_q),
		.idx   (idx),
		.digit (digit)
	);

endmodule

FILE: rtl/core/sitar_conv.sv
// Digit buffer with the shared shift and add-3 unit and the digit selector.
`timescale 1ns / 1ps

module sitar_conv import sitar_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  conv_cmd_t                        cmd,
	input  logic [VALUE_WIDTH-1:0]           mag,
	input  radix_t                           radix,
	input  logic [$clog2(VALUE_WIDTH)-1:0]   idx,
	output logic [3:0]                       digit
);

	localparam int NDEC = VALUE_WIDTH / 3 + 1;
	localparam int DW   = 4 * NDEC;
	localparam int IW   = $clog2(VALUE_WIDTH);
	localparam int SW   = IW + 2;

	logic [DW-1:0]          dig_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [DW-1:0]          adj;
	logic [SW-1:0]          sel_sh;
	logic [DW-1:0]          shifted;

	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			if (dig_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = dig_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = dig_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q  <= mag;
			dig_q <= cmd.dec ? '0 : DW'(mag);
		end else if (cmd.step) begin
			dig_q <= {adj[DW-2:0], sh_q[VALUE_WIDTH-1]};
			sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	always_comb begin
		case (radix)
			RADIX_BIN: sel_sh = SW'(idx);
			RADIX_OCT: sel_sh = SW'({idx, 1'b0}) + SW'(idx);
			default:   sel_sh = SW'({idx, 2'b00});
		endcase
		shifted = dig_q >> sel_sh;
		case (radix)
			RADIX_BIN: digit = {3'd0, shifted[0]};
			RADIX_OCT: digit = {1'b0, shifted[2:0]};
			default:   digit = shifted[3:0];
		endcase
	end

endmodule

FILE: rtl/core/sitar_ctrl.sv
// Sequencer: sign and magnitude, conversion steps, zero skip and the output register.
`timescale 1ns / 1ps

module sitar_ctrl import sitar_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [VALUE_WIDTH-1:0]       value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          character,
	output logic                                last,
	input  radix_t                              radix,
	output conv_cmd_t                           cmd,
	output logic [VALUE_WIDTH-1:0]              mag,
	output logic [$clog2(VALUE_WIDTH)-1:0]      idx,
	input  logic [3:0]                          digit
);

	localparam int IW   = $clog2(VALUE_WIDTH);
	localparam int NOCT = (VALUE_WIDTH + 2) / 3;
	localparam int NDEC = VALUE_WIDTH / 3 + 1;
	localparam int NHEX = (VALUE_WIDTH + 3) / 4;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DABB = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [IW-1:0]          cnt_q, cnt_d;
	logic                   neg_q, neg_d;
	logic                   ov_q, ov_d;
	logic [7:0]             ch_q, ch_d;
	logic                   last_q, last_d;
	logic [VALUE_WIDTH-1:0] val_u;
	logic [IW-1:0]          top_idx;
	logic                   out_free;

	assign val_u = value;
	assign mag   = val_u[VALUE_WIDTH-1] ? VALUE_WIDTH'(~val_u + 1'b1) : val_u;

	always_comb begin
		case (radix)
			RADIX_BIN: top_idx = IW'(VALUE_WIDTH - 1);
			RADIX_OCT: top_idx = IW'(NOCT - 1);
			RADIX_HEX: top_idx = IW'(NHEX - 1);
			default:   top_idx = IW'(NDEC - 1);
		endcase
	end

	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.dec  = (radix == RADIX_DEC);
	assign cmd.step = (state_q == ST_DABB);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		neg_d   = neg_q;
		ov_d    = ov_q && out_stall;
		ch_d    = ch_q;
		last_d  = last_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					neg_d   = val_u[VALUE_WIDTH-1];
					idx_d   = top_idx;
					cnt_d   = IW'(VALUE_WIDTH - 1);
					state_d = (radix == RADIX_DEC) ? ST_DABB : ST_SKIP;
				end
			end
			ST_DABB: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (digit == 4'd0 && idx_q != '0) begin
					idx_d = idx_q - 1'b1;
				end else begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					ov_d    = 1'b1;
					ch_d    = CH_MINUS;
					last_d  = 1'b0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ov_d   = 1'b1;
					ch_d   = digit_char(digit);
					last_d = (idx_q == '0);
					if (idx_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q - 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			neg_q   <= neg_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		ch_q   <= ch_d;
		last_q <= last_d;
	end

	assign idx       = idx_q;
	assign out_valid = ov_q;
	assign character = ch_q;
	assign last      = last_q;

endmodule

FILE: rtl/core/signed_int_to_ascii_radix_unit_chk.sv
// Port-level checker of the radix text unit and its bind.
`timescale 1ns / 1ps
`include "signed_int_to_ascii_radix_unit_assert.svh"

module signed_int_to_ascii_radix_unit_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] character,
	input logic       last
);

	`SITAR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while a number is in flight")
	`SITAR_ASSERT_NEXT(a_text_unbroken, clk, arst_n, out_valid && !out_stall && !last, out_valid, "gap inside the text of a number")
	`SITAR_ASSERT_NOW(a_busy_mid_number, clk, arst_n, out_valid && !last, in_stall, "ready while a number is only partly sent")
	`SITAR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(character) && $stable(last), "stalled output beat changed")

endmodule

bind signed_int_to_ascii_radix_unit signed_int_to_ascii_radix_unit_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last      (last)
);

FILE: sim/tb.sv
// Testbench for the signed integer to ASCII text unit: checks every character against a predictor.
`timescale 1ns / 1ps

module tb;
	import sitar_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 5000;
	localparam int RUN_LIMIT   = 200000;
	localparam int TAIL_CYCLES = 100;
	localparam int CFG_GAP     = 8;
	localparam int PHASE_ITEMS = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} text_beat_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_stall;
	logic [VW-1:0] value     = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [7:0]    character;
	logic          last;
	logic          cfg_we    = 1'b0;
	logic [1:0]    cfg_wdata = '0;

	logic [VW-1:0] value_q [$];
	text_beat_t    text_q [$];
	radix_t        radix_now   = RADIX_RESET;
	logic [3:0]    radix_seen  = '0;
	logic          jitter_on   = 1'b1;
	int            hold_reqs   = 0;
	int            hold_served = 0;
	int            hold_cnt    = 0;
	int            numbers_done = 0;
	int            negatives   = 0;
	int            chars_checked = 0;
	int            errors      = 0;
	int            quiet_cycles = 0;
	int            run_cycles  = 0;

	signed_int_to_ascii_radix_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void predict_text(logic [VW-1:0] v, radix_t r);
		logic [VW-1:0] mag;
		logic [VW-1:0] base;
		logic [3:0]    d;
		logic [7:0]    digs [$];
		mag = v[VW-1] ? (~v + 1'b1) : v;
		case (r)
			RADIX_BIN: base = 2;
			RADIX_OCT: base = 8;
			RADIX_DEC: base = 10;
			default:   base = 16;
		endcase
		do begin
			d = 4'(mag % base);
			digs.push_front(d > DEC_MAX ? CH_ZERO + {4'd0, d} + HEX_GAP : CH_ZERO + {4'd0, d});
			mag = mag / base;
		end while (mag != 0);
		if (v[VW-1])
			text_q.push_back(text_beat_t'{ch: CH_MINUS, is_last: 1'b0});
		foreach (digs[i])
			text_q.push_back(text_beat_t'{ch: digs[i], is_last: i == digs.size() - 1});
	endfunction

	function automatic logic [VW-1:0] pick_value();
		logic [VW-1:0] v;
		logic [VW-1:0] mult;
		int            k;
		case ($urandom_range(4))
			0: v = $urandom;
			1: v = $urandom_range(20);
			2: v = $urandom >> $urandom_range(31);
			3: begin
				case ($urandom_range(3))
					0: mult = 2;
					1: mult = 8;
					2: mult = 10;
					default: mult = 16;
				endcase
				v = 1;
				k = $urandom_range(31);
				repeat (k) v = v * mult;
				v = v - $urandom_range(1);
			end
			default: begin
				case ($urandom_range(3))
					0: v = {1'b0, {(VW-1){1'b1}}};
					1: v = {1'b1, {(VW-1){1'b0}}};
					2: v = {1'b1, {(VW-2){1'b0}}, 1'b1};
					default: v = '0;
				endcase
			end
		endcase
		if ($urandom_range(1))
			v = ~v + 1'b1;
		return v;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_text(value, radix_now);
				radix_seen[radix_now] = 1'b1;
				numbers_done++;
				if (value[VW-1])
					negatives++;
			end
			if (!in_valid || !in_stall) begin
				if (value_q.size() != 0 && !(jitter_on && $urandom_range(99) < 14)) begin
					in_valid <= 1'b1;
					value <= value_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		text_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (text_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat: expected none, actual char %h last %b",
						$time, character, last);
				end else begin
					want = text_q.pop_front();
					chars_checked++;
					if (character !== want.ch) begin
						errors++;
						$display("%0t: character mismatch: expected %h, actual %h",
							$time, want.ch, character);
					end
					if (last !== want.is_last) begin
						errors++;
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.is_last, last);
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1'b1;
			end else if (hold_served != hold_reqs) begin
				hold_served <= hold_served + 1;
				hold_cnt <= HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= jitter_on && $urandom_range(99) < 14;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			run_cycles <= run_cycles + 1;
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
			if (run_cycles >= RUN_LIMIT) begin
				$display("%0t: run still busy after %0d cycles", $time, RUN_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (value_q.size() != 0 || in_valid || in_stall || text_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_radix(radix_t r);
		wait_drained();
		repeat (CFG_GAP) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_now = r;
		@(negedge clk);
	endtask

	task automatic push_corners();
		value_q.push_back('0);
		value_q.push_back(1);
		value_q.push_back('1);
		value_q.push_back({1'b0, {(VW-1){1'b1}}});
		value_q.push_back({1'b1, {(VW-1){1'b0}}});
		value_q.push_back(32'h0ABCDEF9);
	endtask

	task automatic push_random(int n);
		repeat (n) value_q.push_back(pick_value());
	endtask

	initial begin
		radix_t r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners in every radix, decimal from reset first
		push_corners();
		set_radix(RADIX_BIN);
		push_corners();
		set_radix(RADIX_OCT);
		push_corners();
		set_radix(RADIX_HEX);
		push_corners();

		for (int ph = 0; ph < 8; ph++) begin
			r = (ph == 0) ? RADIX_DEC : radix_t'($urandom_range(3));
			set_radix(r);
			jitter_on = (ph != 3);
			if (ph == 5) begin
				hold_reqs++;
				push_random(PHASE_ITEMS);
			end else if (ph == 6) begin
				push_random(PHASE_ITEMS / 2);
				wait_drained();
				push_random(PHASE_ITEMS / 2);
			end else begin
				push_random(PHASE_ITEMS);
			end
		end
		jitter_on = 1'b1;

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (text_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected characters never arrived", $time, text_q.size());
		end

		$display("Converted %0d numbers (%0d negative) into %0d checked characters,",
			numbers_done, negatives, chars_checked);
		$display("radix codes seen %b, with output backpressure and sender pauses.", radix_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sitar_pkg.sv
rtl/core/sitar_conv.sv
rtl/core/sitar_ctrl.sv
rtl/core/signed_int_to_ascii_radix_unit.sv
rtl/core/signed_int_to_ascii_radix_unit_chk.sv
sim/tb.sv
